// ----- hdl/cms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compressed melody sequencer package
// Shared sizes, command codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package cms_pkg;

   localparam int VOICES       = 4;
   localparam int STACK_DEPTH  = 8;
   localparam int STREAM_WORDS = 2048;
   localparam int TREE_ENTRIES = 256;

   localparam int STREAM_AW     = $clog2(STREAM_WORDS);
   localparam int TREE_AW       = $clog2(TREE_ENTRIES);
   localparam int LEVEL_W       = $clog2(STACK_DEPTH);
   localparam int PACKED_VOICES = (VOICES < 4) ? VOICES : 4;

   // Input item kinds.
   localparam logic [2:0] CMD_TICK        = 3'd0;
   localparam logic [2:0] CMD_RESTART     = 3'd1;
   localparam logic [2:0] CMD_STOP        = 3'd2;
   localparam logic [2:0] CMD_LOAD_STREAM = 3'd3;
   localparam logic [2:0] CMD_LOAD_NOTE   = 3'd4;
   localparam logic [2:0] CMD_LOAD_LENGTH = 3'd5;

   // Configuration register indexes.
   localparam logic [2:0] CSR_EVENT_COUNT     = 3'd0;
   localparam logic [2:0] CSR_MIN_REF_LENGTH  = 3'd1;
   localparam logic [2:0] CSR_MIN_REF_OFFSET  = 3'd2;
   localparam logic [2:0] CSR_NOISE_NOTE_CODE = 3'd3;
   localparam logic [2:0] CSR_VOLUME_PERCENT  = 3'd4;
   localparam logic [2:0] CSR_OUTPUT_ENABLE   = 3'd5;

   localparam logic [7:0] FIRST_MIDI      = 8'd47;
   localparam logic [6:0] MAX_VOLUME      = 7'd100;
   localparam logic [4:0] GOLOMB_ZEROS_M1 = 5'd15;
   localparam logic [7:0] TREE_LAST_STEP  = 8'd255;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_TICK_INC,
      OP_EXPIRE,
      OP_RESTART,
      OP_STOP,
      OP_LOAD,
      OP_DEC,
      OP_POP,
      OP_SET_DONE,
      OP_FLAG,
      OP_GOLOMB_ZERO,
      OP_GOLOMB_SUFFIX,
      OP_GOLOMB_DONE,
      OP_PUSH,
      OP_TREE_STEP,
      OP_APPLY,
      OP_FINISH,
      OP_RESULT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   sel;   // second Golomb code, or length tree
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       running;
      logic       stream_done;
      logic       tick_due;
      logic       left_zero;
      logic       level_zero;
      logic       overflow;
      logic       bit_val;
      logic       zeros_zero;
      logic       prefix_end;
      logic       suffix_last;
      logic       tree_end;
      logic       rsp_busy;
   } dp_status_type;

endpackage

// ----- hdl/cms_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- hdl/cms_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequencer datapath
// Stores, replay stack, voices, bit reader and the output register.
// ----------------------------------------------------------------------------
module cms_dp import cms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [15:0]   csr_wdata,
   input  logic [2:0]    req_tuser,
   input  logic [47:0]   req_tdata,
   input  logic          rsp_tready,
   output logic          rsp_tvalid,
   output logic [63:0]   rsp_tdata,
   input  dp_cmd_type    cmd,
   output dp_status_type status
);

   logic [15:0] event_count_ff;
   logic [3:0]  min_ref_length_ff;
   logic [7:0]  min_ref_offset_ff;
   logic [6:0]  noise_note_code_ff;
   logic [6:0]  volume_percent_ff;
   logic        output_enable_ff;

   logic [2:0]  cmd_ff;
   logic [10:0] index_ff;
   logic [31:0] data_ff;

   logic [15:0]        pos_ff  [STACK_DEPTH];
   logic [15:0]        left_ff [STACK_DEPTH];
   logic [LEVEL_W-1:0] level_ff;
   logic [31:0]        tick_now_ff;
   logic [31:0]        tick_next_ff;
   logic [7:0]         voice_code_ff [VOICES];
   logic [31:0]        voice_stop_ff [VOICES];
   logic [5:0]         noise_ff;
   logic [7:0]         last_code_ff;
   logic               running_ff;
   logic               done_ff;
   logic               changed_ff;

   logic [15:0] start_ff;
   logic [15:0] run_ff;
   logic [15:0] dist_ff;
   logic [4:0]  zeros_ff;
   logic [16:0] golomb_ff;
   logic [7:0]  tree_off_ff;
   logic [7:0]  tree_steps_ff;
   logic [6:0]  note_ff;
   logic [7:0]  len_ff;

   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff;

   logic [31:0]        stream_rdata;
   logic [15:0]        note_rdata;
   logic [15:0]        length_rdata;
   logic [15:0]        pos_cur;
   logic [15:0]        left_cur;
   logic               word_ok;
   logic               bit_val;
   logic               tree_ok;
   logic [15:0]        tree_word;
   logic [7:0]         tree_node;
   logic               tree_end;
   logic [7:0]         highest;
   logic [VOICES-1:0]  free_sel;
   logic               free_found;
   logic [16:0]        replay_raw;
   logic [15:0]        replay;
   logic [15:0]        push_pos;
   logic [LEVEL_W-1:0] level_next;
   logic               overflow;
   logic [3:0]         gap;
   logic [5:0]         dur_p1;
   logic [15:0]        golomb_value;
   logic               load_we;
   logic               stream_we;
   logic               note_we;
   logic               length_we;
   logic [31:0]        packed_codes;
   logic [6:0]         volume_sat;

   assign pos_cur  = pos_ff[level_ff];
   assign left_cur = left_ff[level_ff];

   assign load_we   = (cmd.op == OP_LOAD);
   assign stream_we = load_we && (cmd_ff == CMD_LOAD_STREAM)
                      && (32'(index_ff) < 32'(STREAM_WORDS));
   assign note_we   = load_we && (cmd_ff == CMD_LOAD_NOTE)
                      && (32'(index_ff) < 32'(TREE_ENTRIES));
   assign length_we = load_we && (cmd_ff == CMD_LOAD_LENGTH)
                      && (32'(index_ff) < 32'(TREE_ENTRIES));

   cms_ram #(.WIDTH(32), .DEPTH(STREAM_WORDS)) u_stream_ram (
      .clock (clock),
      .we    (stream_we),
      .waddr (index_ff[STREAM_AW-1:0]),
      .wdata (data_ff),
      .raddr (pos_cur[5 +: STREAM_AW]),
      .rdata (stream_rdata)
   );

   cms_ram #(.WIDTH(16), .DEPTH(TREE_ENTRIES)) u_note_ram (
      .clock (clock),
      .we    (note_we),
      .waddr (index_ff[TREE_AW-1:0]),
      .wdata (data_ff[15:0]),
      .raddr (tree_off_ff[TREE_AW-1:0]),
      .rdata (note_rdata)
   );

   cms_ram #(.WIDTH(16), .DEPTH(TREE_ENTRIES)) u_length_ram (
      .clock (clock),
      .we    (length_we),
      .waddr (index_ff[TREE_AW-1:0]),
      .wdata (data_ff[15:0]),
      .raddr (tree_off_ff[TREE_AW-1:0]),
      .rdata (length_rdata)
   );

   // Bits past the end of the stream store read as zero.
   assign word_ok = (32'(pos_cur[15:5]) < 32'(STREAM_WORDS));
   assign bit_val = word_ok & stream_rdata[pos_cur[4:0]];

   assign tree_ok   = (32'(tree_off_ff) < 32'(TREE_ENTRIES));
   assign tree_word = tree_ok ? (cmd.sel ? length_rdata : note_rdata) : 16'd0;
   assign tree_node = bit_val ? tree_word[15:8] : tree_word[7:0];
   assign tree_end  = tree_node[7] || (tree_steps_ff == TREE_LAST_STEP);

   always_comb begin
      highest    = 8'd0;
      free_found = 1'b0;
      free_sel   = '0;
      for (int i = 0; i < VOICES; i++) begin
         if (voice_code_ff[i] > highest) begin
            highest = voice_code_ff[i];
         end
         if (!free_found && (voice_code_ff[i] == 8'd0)) begin
            free_sel[i] = 1'b1;
            free_found  = 1'b1;
         end
      end
   end

   always_comb begin
      packed_codes = 32'd0;
      for (int i = 0; i < PACKED_VOICES; i++) begin
         packed_codes[8*i +: 8] = voice_code_ff[i];
      end
   end

   assign volume_sat = (volume_percent_ff > MAX_VOLUME) ? MAX_VOLUME : volume_percent_ff;

   assign replay_raw   = 17'(run_ff) + 17'(min_ref_length_ff) + 17'd1;
   assign replay       = (replay_raw > 17'(left_cur)) ? left_cur : replay_raw[15:0];
   assign push_pos     = start_ff - (dist_ff + 16'(min_ref_offset_ff) + replay_raw[15:0]);
   assign level_next   = level_ff + 1'b1;
   assign overflow     = (level_ff == LEVEL_W'(STACK_DEPTH - 1));
   assign gap          = (len_ff[2:0] == 3'd7) ? 4'd8 : {1'b0, len_ff[2:0]};
   assign dur_p1       = 6'(len_ff[7:3]) + 6'd1;
   assign golomb_value = 16'(golomb_ff - 17'd1);

   always_comb begin
      status.cmd         = cmd_ff;
      status.running     = running_ff;
      status.stream_done = done_ff;
      status.tick_due    = (tick_now_ff >= tick_next_ff);
      status.left_zero   = (left_cur == 16'd0);
      status.level_zero  = (level_ff == '0);
      status.overflow    = overflow;
      status.bit_val     = bit_val;
      status.zeros_zero  = (zeros_ff == 5'd0);
      status.prefix_end  = bit_val || (zeros_ff == GOLOMB_ZEROS_M1);
      status.suffix_last = (zeros_ff == 5'd1);
      status.tree_end    = tree_end;
      status.rsp_busy    = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         event_count_ff     <= 16'd0;
         min_ref_length_ff  <= 4'd2;
         min_ref_offset_ff  <= 8'd0;
         noise_note_code_ff <= 7'd127;
         volume_percent_ff  <= 7'd70;
         output_enable_ff   <= 1'b1;
         for (int i = 0; i < STACK_DEPTH; i++) begin
            pos_ff[i]  <= 16'd0;
            left_ff[i] <= 16'd0;
         end
         for (int i = 0; i < VOICES; i++) begin
            voice_code_ff[i] <= 8'd0;
            voice_stop_ff[i] <= 32'd0;
         end
         level_ff     <= '0;
         tick_now_ff  <= 32'd0;
         tick_next_ff <= 32'd0;
         noise_ff     <= 6'd0;
         last_code_ff <= 8'd0;
         running_ff   <= 1'b0;
         done_ff      <= 1'b0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_EVENT_COUNT:     event_count_ff     <= csr_wdata;
               CSR_MIN_REF_LENGTH:  min_ref_length_ff  <= csr_wdata[3:0];
               CSR_MIN_REF_OFFSET:  min_ref_offset_ff  <= csr_wdata[7:0];
               CSR_NOISE_NOTE_CODE: noise_note_code_ff <= csr_wdata[6:0];
               CSR_VOLUME_PERCENT:  volume_percent_ff  <= csr_wdata[6:0];
               CSR_OUTPUT_ENABLE:   output_enable_ff   <= csr_wdata[0];
               default: ;
            endcase
         end

         if (rsp_tready && (cmd.op != OP_RESULT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (cmd.op)
            OP_CAPTURE: begin
               cmd_ff     <= req_tuser;
               index_ff   <= req_tdata[10:0];
               data_ff    <= req_tdata[42:11];
               changed_ff <= 1'b0;
            end
            OP_TICK_INC: begin
               tick_now_ff <= tick_now_ff + 32'd1;
            end
            OP_EXPIRE: begin
               for (int i = 0; i < VOICES; i++) begin
                  if ((voice_code_ff[i] != 8'd0) && (voice_stop_ff[i] <= tick_now_ff)) begin
                     voice_code_ff[i] <= 8'd0;
                  end
               end
            end
            OP_RESTART: begin
               // The bottom entry holds the whole song's event count plus one.
               for (int i = 0; i < STACK_DEPTH; i++) begin
                  pos_ff[i]  <= 16'd0;
                  left_ff[i] <= (i == 0) ? event_count_ff + 16'd1 : 16'd0;
               end
               for (int i = 0; i < VOICES; i++) begin
                  voice_code_ff[i] <= 8'd0;
                  voice_stop_ff[i] <= 32'd0;
               end
               level_ff     <= '0;
               tick_now_ff  <= 32'd0;
               tick_next_ff <= 32'd0;
               noise_ff     <= 6'd0;
               last_code_ff <= 8'd0;
               done_ff      <= 1'b0;
               running_ff   <= 1'b1;
            end
            OP_STOP: begin
               last_code_ff <= 8'd0;
               running_ff   <= 1'b0;
            end
            OP_DEC: begin
               left_ff[level_ff] <= left_cur - 16'd1;
            end
            OP_POP: begin
               level_ff <= level_ff - 1'b1;
            end
            OP_SET_DONE: begin
               done_ff <= 1'b1;
            end
            OP_FLAG: begin
               start_ff         <= pos_cur;
               pos_ff[level_ff] <= pos_cur + 16'd1;
               zeros_ff         <= 5'd0;
               golomb_ff        <= 17'd1;
               tree_off_ff      <= 8'd0;
               tree_steps_ff    <= 8'd0;
            end
            OP_GOLOMB_ZERO: begin
               pos_ff[level_ff] <= pos_cur + 16'd1;
               if (!bit_val) begin
                  zeros_ff <= zeros_ff + 5'd1;
               end
            end
            OP_GOLOMB_SUFFIX: begin
               pos_ff[level_ff] <= pos_cur + 16'd1;
               golomb_ff        <= {golomb_ff[15:0], bit_val};
               zeros_ff         <= zeros_ff - 5'd1;
            end
            OP_GOLOMB_DONE: begin
               if (cmd.sel) begin
                  dist_ff <= golomb_value;
               end else begin
                  run_ff <= golomb_value;
               end
               zeros_ff  <= 5'd0;
               golomb_ff <= 17'd1;
            end
            OP_PUSH: begin
               left_ff[level_ff] <= left_cur - replay;
               if (overflow) begin
                  done_ff <= 1'b1;
               end else begin
                  level_ff            <= level_next;
                  pos_ff[level_next]  <= push_pos;
                  left_ff[level_next] <= replay;
               end
            end
            OP_TREE_STEP: begin
               pos_ff[level_ff] <= pos_cur + 16'd1;
               if (tree_end) begin
                  if (cmd.sel) begin
                     len_ff <= tree_node[7] ? {1'b0, tree_node[6:0]} : 8'd0;
                  end else begin
                     note_ff <= tree_node[7] ? tree_node[6:0] : 7'd0;
                  end
                  tree_off_ff   <= 8'd0;
                  tree_steps_ff <= 8'd0;
               end else begin
                  tree_off_ff   <= tree_off_ff + tree_node + 8'd1;
                  tree_steps_ff <= tree_steps_ff + 8'd1;
               end
            end
            OP_APPLY: begin
               tick_next_ff <= tick_now_ff + 32'(gap);
               if (note_ff == noise_note_code_ff) begin
                  if (dur_p1 > noise_ff) begin
                     noise_ff <= dur_p1;
                  end
               end else begin
                  for (int i = 0; i < VOICES; i++) begin
                     if (free_sel[i]) begin
                        voice_code_ff[i] <= 8'(note_ff) + 8'd1;
                        voice_stop_ff[i] <= tick_now_ff + 32'(dur_p1);
                     end
                  end
               end
            end
            OP_FINISH: begin
               // When the song has ended in silence the highest code is zero,
               // so taking it also clears the shown note.
               if ((output_enable_ff && (highest != last_code_ff))
                   || (done_ff && (highest == 8'd0))) begin
                  last_code_ff <= highest;
               end
               if (output_enable_ff && (highest != last_code_ff)) begin
                  changed_ff <= 1'b1;
               end
               if (done_ff && (highest == 8'd0)) begin
                  running_ff <= 1'b0;
               end
            end
            OP_RESULT: begin
               rsp_valid_ff        <= 1'b1;
               rsp_data_ff[31:0]   <= packed_codes;
               rsp_data_ff[39:32]  <= highest;
               rsp_data_ff[47:40]  <= (highest != 8'd0) ? (highest + (FIRST_MIDI - 8'd1))
                                                        : 8'd0;
               rsp_data_ff[54:48]  <= (output_enable_ff && (highest != 8'd0)) ? volume_sat
                                                                               : 7'd0;
               rsp_data_ff[55]     <= changed_ff;
               rsp_data_ff[61:56]  <= (cmd_ff == CMD_TICK) ? noise_ff : 6'd0;
               rsp_data_ff[62]     <= running_ff;
               rsp_data_ff[63]     <= !running_ff && done_ff;
               if (cmd_ff == CMD_TICK) begin
                  noise_ff <= 6'd0;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// ----- hdl/cms_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequencer controller
// Steps the datapath through command handling and event decoding.
// ----------------------------------------------------------------------------
module cms_ctrl import cms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_EXPIRE, S_CHECK, S_POP,
      S_FLAG_W, S_FLAG, S_GZ_W, S_GZ, S_GS_W, S_GS, S_GDONE, S_PUSH,
      S_TREE_W, S_TREE, S_APPLY, S_FINISH, S_RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      second_ff;
   logic      tree_sel_ff;

   assign req_tready = ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      cmd.sel  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_RESULT;
            case (status.cmd)
               CMD_TICK: begin
                  if (status.running) begin
                     cmd.op   = OP_TICK_INC;
                     state_in = S_EXPIRE;
                  end
               end
               CMD_RESTART:     cmd.op = OP_RESTART;
               CMD_STOP:        cmd.op = OP_STOP;
               CMD_LOAD_STREAM: cmd.op = OP_LOAD;
               CMD_LOAD_NOTE:   cmd.op = OP_LOAD;
               CMD_LOAD_LENGTH: cmd.op = OP_LOAD;
               default: ;
            endcase
         end
         S_EXPIRE: begin
            cmd.op   = OP_EXPIRE;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!status.stream_done && status.tick_due) begin
               cmd.op   = OP_DEC;
               state_in = S_POP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_POP: begin
            if (status.left_zero) begin
               if (status.level_zero) begin
                  cmd.op   = OP_SET_DONE;
                  state_in = S_FINISH;
               end else begin
                  cmd.op = OP_POP;
               end
            end else begin
               state_in = S_FLAG_W;
            end
         end
         S_FLAG_W: state_in = S_FLAG;
         S_FLAG: begin
            cmd.op   = OP_FLAG;
            state_in = status.bit_val ? S_GZ_W : S_TREE_W;
         end
         S_GZ_W: state_in = S_GZ;
         S_GZ: begin
            cmd.op = OP_GOLOMB_ZERO;
            if (status.prefix_end) begin
               state_in = (status.bit_val && status.zeros_zero) ? S_GDONE : S_GS_W;
            end else begin
               state_in = S_GZ_W;
            end
         end
         S_GS_W: state_in = S_GS;
         S_GS: begin
            cmd.op   = OP_GOLOMB_SUFFIX;
            state_in = status.suffix_last ? S_GDONE : S_GS_W;
         end
         S_GDONE: begin
            cmd.op   = OP_GOLOMB_DONE;
            cmd.sel  = second_ff;
            state_in = second_ff ? S_PUSH : S_GZ_W;
         end
         S_PUSH: begin
            cmd.op   = OP_PUSH;
            state_in = status.overflow ? S_FINISH : S_FLAG_W;
         end
         S_TREE_W: begin
            cmd.sel  = tree_sel_ff;
            state_in = S_TREE;
         end
         S_TREE: begin
            cmd.op  = OP_TREE_STEP;
            cmd.sel = tree_sel_ff;
            if (status.tree_end) begin
               state_in = tree_sel_ff ? S_APPLY : S_TREE_W;
            end else begin
               state_in = S_TREE_W;
            end
         end
         S_APPLY: begin
            cmd.op   = OP_APPLY;
            state_in = S_CHECK;
         end
         S_FINISH: begin
            cmd.op   = OP_FINISH;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!status.rsp_busy) begin
               cmd.op   = OP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ready_ff    <= 1'b1;
         second_ff   <= 1'b0;
         tree_sel_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
         case (state_ff)
            S_FLAG: begin
               second_ff   <= 1'b0;
               tree_sel_ff <= 1'b0;
            end
            S_GDONE: second_ff <= 1'b1;
            S_TREE: begin
               if (status.tree_end) begin
                  tree_sel_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// ----- hdl/compressed_melody_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compressed melody sequencer
// Plays a Huffman and back-reference compressed note stream, one tick per item.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the req_ channel (tuser holds the command code),
// and every command gives exactly one status transfer on the rsp_ channel.
// Load commands fill the stream word store and the two tree stores; restart,
// stop and tick control playback. Configuration is written through csr_ while
// no command is in flight.
// Steps: load, restart, stop and idle ticks go from capture through dispatch
// to the result state. A playing tick also passes expire, check and finish and,
// for each decoded event, reads stream bits one at a time; the single stream
// store read port sets that pace, since every Golomb and tree bit waits in a
// wait state for a registered read.
// One command is handled at a time; the next is taken once the result is in
// the output register, even if the receiver has not taken it yet.
// Reset clears playback state and loads the register defaults; the stores
// keep their contents and need no clearing pass. A stalled receiver holds the
// result, and the block then waits before writing the next one.
// ----------------------------------------------------------------------------
module compressed_melody_sequencer import cms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,    // index[10:0], data[42:11], zero fill
   input  logic [2:0]  req_tuser,    // cmd[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // voice_codes[31:0], highest_code[39:32],
                                     // midi_note[47:40], tone_volume[54:48],
                                     // note_changed[55], noise_ticks[61:56],
                                     // running[62], finished[63]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // The controller sequences each command; the stores and playback state live in the datapath.
   cms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   cms_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (dp_cmd),
      .status     (dp_status)
   );

`ifndef SYNTHESIS
   // One command at a time: a transfer closes the input until its result exists.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted twice without a result");

   // Finished and running are never reported together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[63] && rsp_tdata[62]))
      else $error("finished reported while running");

   // The MIDI number is zero exactly when no voice sounds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[39:32] == 8'd0) == (rsp_tdata[47:40] == 8'd0)))
      else $error("midi note and highest code disagree");
`endif

endmodule
